### hw/rtl/jqtpd_pkg.sv
package jqtpd_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int TAU_W    = 28;
    localparam int DIV_W    = 66;
    localparam int H_W      = 40;
    localparam int ACC_W    = 52;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_TRACK = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [2:0] REG_KP      = 3'd0;
    localparam logic [2:0] REG_KD      = 3'd1;
    localparam logic [2:0] REG_INERTIA = 3'd2;
    localparam logic [2:0] REG_LIMIT   = 3'd3;
    localparam logic [2:0] REG_PERIOD  = 3'd4;
    localparam logic [2:0] REG_RATE    = 3'd5;
    localparam logic [2:0] REG_SIM     = 3'd6;
    localparam logic [2:0] REG_HOME    = 3'd7;

    localparam logic signed [H_W-1:0] ONE_T = 40'sd268435456;

    localparam logic signed [65:0] SMAX66 = 66'sd2147483647;
    localparam logic signed [65:0] SMIN66 = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > SMAX66) begin
            r = 32'sh7fffffff;
        end else if (v < SMIN66) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // sign applied to a quotient capped at 2^31, then saturated
    function automatic logic signed [31:0] cap_sat(input logic neg, input logic [65:0] q);
        logic signed [31:0] r;
        if (neg) begin
            r = (q >= 66'd2147483648) ? 32'sh80000000 : $signed(32'(32'd0 - q[31:0]));
        end else begin
            r = (q >= 66'd2147483647) ? 32'sh7fffffff : $signed(q[31:0]);
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] r;
        r = v[63] ? 64'(-v) : 64'(v);
        return r;
    endfunction

    function automatic logic signed [65:0] apply_sign(input logic neg, input logic [63:0] m);
        logic signed [65:0] r;
        r = $signed({2'b00, m});
        if (neg) begin
            r = -r;
        end
        return r;
    endfunction

    // c1*tau - c0, first Horner term of a shape polynomial
    function automatic logic signed [H_W-1:0] hinit(input logic [TAU_W:0] tau,
                                                    input logic signed [H_W-1:0] c1,
                                                    input logic signed [H_W-1:0] c0);
        logic signed [H_W-1:0] r;
        r = $signed({11'b0, tau}) * c1 - c0;
        return r;
    endfunction

endpackage

### hw/rtl/joint_quintic_trajectory_pd_core.sv
// One joint of a quintic rest-to-rest trajectory follower with computed-torque PD.
// Input channel s_*: one request per control tick; opcode in s_tuser, angle,
// target and move duration in s_tdata. Result channel m_*: torque, desired angle
// and velocity estimate in m_tdata, drive_on in m_tuser. cfg_* writes registers.
// A single 32x32 multiplier, run over four partial products per 64-bit
// multiply, and a radix-2 divider are stepped by a small sequencer.
// A tracking request with nonzero path duration takes 17 multiplies, 4 divides.
// s_tready is high only while the sequencer is idle; one request at a time.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, the sequencer holds its final step until
// the output register is free.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// path state and sets the desired angle to zero. Writing home_position also
// loads the desired angle.
module joint_quintic_trajectory_pd_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // measured_position, target_position, move_duration
    input  logic [1:0]   s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // torque_command, desired_position, velocity_estimate
    output logic         m_tuser,   // drive_on
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_STEP = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        PC_VEL, PC_TIME, PC_TAU, PC_HORNER, PC_POS, PC_PV, PC_VD, PC_PA,
        PC_X1, PC_AD, PC_GAIN, PC_GKD, PC_GKP, PC_INR
    } pc_t;

    state_t state_reg, state_next;
    pc_t    pc_reg, pc_next;

    logic [30:0] kp_reg, kp_next, kd_reg, kd_next;
    logic [30:0] inertia_reg, inertia_next, limit_reg, limit_next;
    logic [31:0] period_reg, period_next;
    logic [19:0] rate_reg, rate_next;
    logic        sim_reg, sim_next;

    logic [1:0]         op_reg, op_next;
    logic signed [31:0] meas_reg, meas_next, tgt_reg, tgt_next;
    logic [30:0]        mdur_reg, mdur_next;
    logic signed [31:0] prevpos_reg, prevpos_next, desired_reg, desired_next;
    logic signed [31:0] start_reg, start_next, dist_reg, dist_next;
    logic [30:0]        dur_reg, dur_next;
    logic [31:0]        tick_reg, tick_next;

    logic signed [31:0] vel_reg, vel_next;
    logic [28:0]        tau_reg, tau_next;
    logic signed [39:0] h_reg, h_next, s_reg, s_next, v_reg, v_next, a_reg, a_next;
    logic [3:0]         hk_reg, hk_next;
    logic signed [31:0] posd_reg, posd_next, veld_reg, veld_next, accd_reg, accd_next;
    logic signed [51:0] accel_reg, accel_next;

    logic [63:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [63:0]  pp_reg, pp_next;
    logic [127:0] prod_reg, prod_next;
    logic [2:0]   mcnt_reg, mcnt_next;
    logic         mneg_reg, mneg_next;

    logic [65:0] dq_reg, dq_next;
    logic [31:0] dr_reg, dr_next;
    logic [6:0]  dcnt_reg, dcnt_next;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] out_torque_reg, out_torque_next, out_des_reg, out_des_next;
    logic signed [31:0] out_vel_reg, out_vel_next;
    logic               out_drive_reg, out_drive_next;

    logic               do_mul, do_div, lneg;
    logic [63:0]        la, lb;
    logic [65:0]        ldiv;
    pc_t                lpc;
    logic               out_free, tracking;
    logic signed [31:0] meas_in;
    logic signed [32:0] diff_in, e_vel, e_pos;
    logic [31:0]        a_part, b_part;
    logic [1:0]         pj;
    logic [127:0]       pp_shift;
    logic [31:0]        dtmp;
    logic               dge;
    logic signed [65:0] sgn_full, r28, g16;
    logic signed [39:0] hr, hn;
    logic [47:0]        tfull, mfull;
    logic [30:0]        t_clamp, m_cl;
    logic signed [51:0] acc_sum;
    logic signed [31:0] vel_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_vel_reg, out_des_reg, out_torque_reg};
    assign m_tuser  = out_drive_reg;

    always_comb begin
        state_next = state_reg;   pc_next = pc_reg;
        kp_next = kp_reg;         kd_next = kd_reg;
        inertia_next = inertia_reg; limit_next = limit_reg;
        period_next = period_reg; rate_next = rate_reg; sim_next = sim_reg;
        op_next = op_reg;         meas_next = meas_reg; tgt_next = tgt_reg;
        mdur_next = mdur_reg;     prevpos_next = prevpos_reg;
        desired_next = desired_reg; start_next = start_reg; dist_next = dist_reg;
        dur_next = dur_reg;       tick_next = tick_reg;
        vel_next = vel_reg;       tau_next = tau_reg;
        h_next = h_reg; s_next = s_reg; v_next = v_reg; a_next = a_reg;
        hk_next = hk_reg;
        posd_next = posd_reg; veld_next = veld_reg; accd_next = accd_reg;
        accel_next = accel_reg;
        mul_a_next = mul_a_reg; mul_b_next = mul_b_reg; pp_next = pp_reg;
        prod_next = prod_reg; mcnt_next = mcnt_reg; mneg_next = mneg_reg;
        dq_next = dq_reg; dr_next = dr_reg; dcnt_next = dcnt_reg;
        m_valid_next = m_valid_reg;
        out_torque_next = out_torque_reg; out_des_next = out_des_reg;
        out_vel_next = out_vel_reg; out_drive_next = out_drive_reg;

        do_mul = 1'b0; do_div = 1'b0; la = '0; lb = '0; ldiv = '0;
        lneg = mneg_reg; lpc = pc_reg;

        meas_in  = sim_reg ? desired_reg : $signed(s_tdata[31:0]);
        diff_in  = 33'(meas_in) - 33'(prevpos_reg);
        e_vel    = 33'(veld_reg) - 33'(vel_reg);
        e_pos    = 33'(posd_reg) - 33'(meas_reg);
        tracking = (op_reg == jqtpd_pkg::OP_TRACK) || (op_reg == jqtpd_pkg::OP_START);

        a_part   = mcnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        b_part   = mcnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        pj       = 2'(mcnt_reg - 3'd1);
        case (pj)
            2'd0:    pp_shift = 128'(pp_reg);
            2'd3:    pp_shift = {pp_reg, 64'b0};
            default: pp_shift = {32'b0, pp_reg, 32'b0};
        endcase

        dtmp = {dr_reg[30:0], dq_reg[65]};
        dge  = (dtmp >= {1'b0, dur_reg});

        sgn_full = jqtpd_pkg::apply_sign(mneg_reg, prod_reg[63:0]);
        r28      = jqtpd_pkg::apply_sign(mneg_reg, 64'(prod_reg[63:28]));
        g16      = jqtpd_pkg::apply_sign(mneg_reg, 64'(prod_reg[63:16]));
        hr       = r28[39:0];
        hn       = hr;
        vel_new  = jqtpd_pkg::sat32(sgn_full);
        tfull    = prod_reg[63:16];
        t_clamp  = (tfull > 48'(dur_reg)) ? dur_reg : tfull[30:0];
        acc_sum  = accel_reg + $signed(g16[51:0]);
        mfull    = (|prod_reg[127:64]) ? 48'(limit_reg) : prod_reg[63:16];
        m_cl     = (mfull > 48'(limit_reg)) ? limit_reg : mfull[30:0];
        out_free = !m_valid_reg || m_tready;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_index)
                jqtpd_pkg::REG_KP:      kp_next = cfg_data[30:0];
                jqtpd_pkg::REG_KD:      kd_next = cfg_data[30:0];
                jqtpd_pkg::REG_INERTIA: inertia_next = cfg_data[30:0];
                jqtpd_pkg::REG_LIMIT:   limit_next = cfg_data[30:0];
                jqtpd_pkg::REG_PERIOD:  period_next = cfg_data;
                jqtpd_pkg::REG_RATE:    rate_next = cfg_data[19:0];
                jqtpd_pkg::REG_SIM:     sim_next = cfg_data[0];
                jqtpd_pkg::REG_HOME:    desired_next = $signed(cfg_data);
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    meas_next = meas_in;
                    tgt_next  = $signed(s_tdata[63:32]);
                    mdur_next = s_tdata[94:64];
                    do_mul = 1'b1;
                    la = jqtpd_pkg::mag64(64'(diff_in));
                    lb = 64'(rate_reg);
                    lneg = diff_in[32];
                    lpc = PC_VEL;
                end
            end
            ST_MUL: begin
                if (mcnt_reg != 3'd4) begin
                    pp_next = a_part * b_part;
                end
                if (mcnt_reg != 3'd0) begin
                    prod_next = prod_reg + pp_shift;
                end
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd4) begin
                    state_next = ST_STEP;
                end
            end
            ST_DIV: begin
                dr_next = dge ? (dtmp - {1'b0, dur_reg}) : dtmp;
                dq_next = {dq_reg[64:0], dge};
                dcnt_next = dcnt_reg + 7'd1;
                if (dcnt_reg == 7'(jqtpd_pkg::DIV_W - 1)) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                case (pc_reg)
                    PC_VEL: begin
                        if (tracking || out_free) begin
                            vel_next = vel_new;
                            prevpos_next = meas_reg;
                            if (op_reg == jqtpd_pkg::OP_START) begin
                                start_next = meas_reg;
                                dist_next  = jqtpd_pkg::sat32(66'(tgt_reg) - 66'(meas_reg));
                                dur_next   = mdur_reg;
                                tick_next  = '0;
                            end
                            if (tracking) begin
                                do_mul = 1'b1;
                                la = (op_reg == jqtpd_pkg::OP_START) ? 64'd0 : 64'(tick_reg);
                                lb = 64'(period_reg);
                                lneg = 1'b0;
                                lpc = PC_TIME;
                            end else begin
                                m_valid_next    = 1'b1;
                                out_torque_next = '0;
                                out_drive_next  = 1'b0;
                                out_des_next    = desired_reg;
                                out_vel_next    = vel_new;
                                state_next      = ST_IDLE;
                            end
                        end
                    end
                    PC_TIME: begin
                        if (dur_reg == '0) begin
                            posd_next = jqtpd_pkg::sat32(66'(start_reg) + 66'(dist_reg));
                            veld_next = '0;
                            accd_next = '0;
                            pc_next = PC_GAIN;
                        end else begin
                            do_div = 1'b1;
                            ldiv = 66'({t_clamp, 28'b0});
                            lpc = PC_TAU;
                        end
                    end
                    PC_TAU: begin
                        tau_next = dq_reg[28:0];
                        hn = jqtpd_pkg::hinit(dq_reg[28:0], 40'sd6, 40'sd15 * jqtpd_pkg::ONE_T);
                        h_next = hn;
                        hk_next = '0;
                        do_mul = 1'b1;
                        la = jqtpd_pkg::mag64(64'(hn));
                        lb = 64'(dq_reg[28:0]);
                        lneg = hn[39];
                        lpc = PC_HORNER;
                    end
                    PC_HORNER: begin
                        case (hk_reg)
                            4'd0: hn = hr + 40'sd10 * jqtpd_pkg::ONE_T;
                            4'd3: begin
                                s_next = hr;
                                hn = jqtpd_pkg::hinit(tau_reg, 40'sd30,
                                                      40'sd60 * jqtpd_pkg::ONE_T);
                            end
                            4'd4: hn = hr + 40'sd30 * jqtpd_pkg::ONE_T;
                            4'd6: begin
                                v_next = hr;
                                hn = jqtpd_pkg::hinit(tau_reg, 40'sd120,
                                                      40'sd180 * jqtpd_pkg::ONE_T);
                            end
                            4'd7: hn = hr + 40'sd60 * jqtpd_pkg::ONE_T;
                            default: hn = hr;
                        endcase
                        do_mul = 1'b1;
                        if (hk_reg == 4'd8) begin
                            a_next = hr;
                            la = jqtpd_pkg::mag64(64'(dist_reg));
                            lb = jqtpd_pkg::mag64(64'(s_reg));
                            lneg = dist_reg[31] ^ s_reg[39];
                            lpc = PC_POS;
                        end else begin
                            h_next = hn;
                            hk_next = hk_reg + 4'd1;
                            la = jqtpd_pkg::mag64(64'(hn));
                            lb = 64'(tau_reg);
                            lneg = hn[39];
                        end
                    end
                    PC_POS: begin
                        posd_next = jqtpd_pkg::sat32(66'(start_reg) + r28);
                        do_mul = 1'b1;
                        la = jqtpd_pkg::mag64(64'(dist_reg));
                        lb = jqtpd_pkg::mag64(64'(v_reg));
                        lneg = dist_reg[31] ^ v_reg[39];
                        lpc = PC_PV;
                    end
                    PC_PV: begin
                        do_div = 1'b1;
                        ldiv = 66'(prod_reg[63:12]);
                        lpc = PC_VD;
                    end
                    PC_VD: begin
                        veld_next = jqtpd_pkg::cap_sat(mneg_reg, dq_reg);
                        do_mul = 1'b1;
                        la = jqtpd_pkg::mag64(64'(dist_reg));
                        lb = jqtpd_pkg::mag64(64'(a_reg));
                        lneg = dist_reg[31] ^ a_reg[39];
                        lpc = PC_PA;
                    end
                    PC_PA: begin
                        do_div = 1'b1;
                        ldiv = {prod_reg[61:0], 4'b0};
                        lpc = PC_X1;
                    end
                    PC_X1: begin
                        do_div = 1'b1;
                        ldiv = dq_reg;
                        lpc = PC_AD;
                    end
                    PC_AD: begin
                        accd_next = jqtpd_pkg::cap_sat(mneg_reg, dq_reg);
                        pc_next = PC_GAIN;
                    end
                    PC_GAIN: begin
                        do_mul = 1'b1;
                        la = jqtpd_pkg::mag64(64'(e_vel));
                        lb = 64'(kd_reg);
                        lneg = e_vel[32];
                        lpc = PC_GKD;
                    end
                    PC_GKD: begin
                        accel_next = 52'(accd_reg) + $signed(g16[51:0]);
                        do_mul = 1'b1;
                        la = jqtpd_pkg::mag64(64'(e_pos));
                        lb = 64'(kp_reg);
                        lneg = e_pos[32];
                        lpc = PC_GKP;
                    end
                    PC_GKP: begin
                        accel_next = acc_sum;
                        do_mul = 1'b1;
                        la = jqtpd_pkg::mag64(64'(acc_sum));
                        lb = 64'(inertia_reg);
                        lneg = acc_sum[51];
                        lpc = PC_INR;
                    end
                    PC_INR: begin
                        if (out_free) begin
                            m_valid_next    = 1'b1;
                            out_drive_next  = !sim_reg;
                            out_torque_next = sim_reg ? 32'sd0 :
                                              (mneg_reg ? -$signed({1'b0, m_cl})
                                                        : $signed({1'b0, m_cl}));
                            out_des_next    = posd_reg;
                            out_vel_next    = vel_reg;
                            desired_next    = posd_reg;
                            if (tick_reg != '1) begin
                                tick_next = tick_reg + 32'd1;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase

        if (do_mul) begin
            state_next = ST_MUL;
            mul_a_next = la;
            mul_b_next = lb;
            mneg_next  = lneg;
            mcnt_next  = '0;
            prod_next  = '0;
            pc_next    = lpc;
        end
        if (do_div) begin
            state_next = ST_DIV;
            dq_next    = ldiv;
            dr_next    = '0;
            dcnt_next  = '0;
            pc_next    = lpc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= PC_VEL;
            kp_reg      <= '0;
            kd_reg      <= '0;
            inertia_reg <= 31'd65536;
            limit_reg   <= '0;
            period_reg  <= 32'd4294967;
            rate_reg    <= 20'd1000;
            sim_reg     <= 1'b0;
            prevpos_reg <= '0;
            desired_reg <= '0;
            start_reg   <= '0;
            dist_reg    <= '0;
            dur_reg     <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
            mcnt_reg    <= '0;
            dcnt_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            kp_reg      <= kp_next;
            kd_reg      <= kd_next;
            inertia_reg <= inertia_next;
            limit_reg   <= limit_next;
            period_reg  <= period_next;
            rate_reg    <= rate_next;
            sim_reg     <= sim_next;
            prevpos_reg <= prevpos_next;
            desired_reg <= desired_next;
            start_reg   <= start_next;
            dist_reg    <= dist_next;
            dur_reg     <= dur_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
            mcnt_reg    <= mcnt_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        meas_reg  <= meas_next;
        tgt_reg   <= tgt_next;
        mdur_reg  <= mdur_next;
        vel_reg   <= vel_next;
        tau_reg   <= tau_next;
        h_reg     <= h_next;
        s_reg     <= s_next;
        v_reg     <= v_next;
        a_reg     <= a_next;
        hk_reg    <= hk_next;
        posd_reg  <= posd_next;
        veld_reg  <= veld_next;
        accd_reg  <= accd_next;
        accel_reg <= accel_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        pp_reg    <= pp_next;
        prod_reg  <= prod_next;
        mneg_reg  <= mneg_next;
        dq_reg    <= dq_next;
        dr_reg    <= dr_next;
        out_torque_reg <= out_torque_next;
        out_des_reg    <= out_des_next;
        out_vel_reg    <= out_vel_next;
        out_drive_reg  <= out_drive_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while sequencer stays idle");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> dur_reg != '0)
        else $error("divide by zero duration");

    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |-> mcnt_reg <= 3'd4)
        else $error("multiplier step count overrun");

    a_drive_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_drive_reg |-> out_torque_reg == '0)
        else $error("torque present with drive off");

endmodule

### test/jqtpd_checker.sv
`timescale 1ns / 1ps

module jqtpd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          pending,
    output int          errors
);

    localparam longint UNIT_TAU = 64'sd268435456;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] torque;
        logic        drive;
        logic [31:0] angle;
        logic [31:0] vel;
    } tick_result_t;

    tick_result_t want_q[$];

    longint unsigned kp, kd, inertia, tlimit, period, rate;
    logic            sim;
    longint          home, last_pos, des_angle, path_from, path_dist;
    longint unsigned path_time, ticks;

    function automatic longint sat32(longint v);
        return v > SMAX ? SMAX : (v < SMIN ? SMIN : v);
    endfunction

    function automatic longint unsigned mag(longint v);
        return longint'(v < 0 ? -v : v);
    endfunction

    function automatic longint with_sign(logic neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mul_trunc(longint a, longint b, int sh);
        longint unsigned m;
        m = (mag(a) * mag(b)) >> sh;
        return with_sign((a < 0) != (b < 0), m);
    endfunction

    function automatic longint unsigned cap31(longint unsigned m);
        return m > 64'd2147483648 ? 64'd2147483648 : m;
    endfunction

    function automatic tick_result_t servo_tick(logic [1:0] op, logic [95:0] d);
        tick_result_t res;
        longint meas, vel, torque, move_dist, pos_d, vel_d, acc_d, accel, tau, h, s, v, a;
        longint unsigned t, tt, p, q, r, m;
        logic neg, drive;
        logic signed [31:0] in_meas, in_tgt;
        in_meas = d[31:0];
        in_tgt = d[63:32];
        meas = sim ? des_angle : longint'(in_meas);
        vel = sat32((meas - last_pos) * longint'(rate));
        torque = 0;
        drive = 0;
        last_pos = meas;
        if (op == jqtpd_pkg::OP_START) begin
            path_from = meas;
            path_dist = sat32(longint'(in_tgt) - meas);
            path_time = 64'(d[94:64]);
            ticks = 0;
        end
        if (op == jqtpd_pkg::OP_TRACK || op == jqtpd_pkg::OP_START) begin
            tt = path_time;
            t = (ticks * period) >> 16;
            move_dist = path_dist;
            vel_d = 0;
            acc_d = 0;
            if (t > tt) t = tt;
            if (tt == 0) begin
                pos_d = sat32(path_from + move_dist);
            end else begin
                tau = longint'((t << 28) / tt);
                h = 6 * tau - 15 * UNIT_TAU;
                h = mul_trunc(h, tau, 28) + 10 * UNIT_TAU;
                h = mul_trunc(h, tau, 28);
                h = mul_trunc(h, tau, 28);
                s = mul_trunc(h, tau, 28);
                h = 30 * tau - 60 * UNIT_TAU;
                h = mul_trunc(h, tau, 28) + 30 * UNIT_TAU;
                h = mul_trunc(h, tau, 28);
                v = mul_trunc(h, tau, 28);
                h = 120 * tau - 180 * UNIT_TAU;
                h = mul_trunc(h, tau, 28) + 60 * UNIT_TAU;
                a = mul_trunc(h, tau, 28);
                pos_d = sat32(path_from + mul_trunc(move_dist, s, 28));
                neg = (move_dist < 0) != (v < 0);
                p = mag(move_dist) * mag(v);
                vel_d = sat32(with_sign(neg, cap31((p >> 12) / tt)));
                neg = (move_dist < 0) != (a < 0);
                p = mag(move_dist) * mag(a);
                q = p / tt;
                r = p % tt;
                if (q >= (64'd1 << 58)) m = 64'd2147483648;
                else m = cap31(((q << 4) + ((r << 4) / tt)) / tt);
                acc_d = sat32(with_sign(neg, m));
            end
            des_angle = pos_d;
            if (ticks < 64'hFFFFFFFF) ticks++;
            accel = acc_d + mul_trunc(vel_d - vel, longint'(kd), 16)
                    + mul_trunc(pos_d - meas, longint'(kp), 16);
            m = mag(accel);
            if (inertia != 0 && m > 64'hFFFFFFFFFFFFFFFF / inertia) m = tlimit;
            else m = (m * inertia) >> 16;
            if (m > tlimit) m = tlimit;
            if (!sim) begin
                torque = with_sign(accel < 0, m);
                drive = 1;
            end
        end
        res.torque = torque[31:0];
        res.drive = drive;
        res.angle = des_angle[31:0];
        res.vel = vel[31:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        tick_result_t want;
        logic signed [31:0] hv;
        if (!aresetn) begin
            kp = 0; kd = 0; inertia = 65536; tlimit = 0;
            period = 4294967; rate = 1000; sim = 0; home = 0;
            last_pos = 0; des_angle = 0; path_from = 0; path_dist = 0;
            path_time = 0; ticks = 0;
            want_q.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (want_q.size() == 0) begin
                    $display("%0t: result with none expected: %h %b", $realtime, m_tdata, m_tuser);
                    errors++;
                end else begin
                    want = want_q.pop_front();
                    if (m_tdata[31:0] !== want.torque || m_tuser !== want.drive
                        || m_tdata[63:32] !== want.angle || m_tdata[95:64] !== want.vel) begin
                        $display("%0t: mismatch expected torque %h drive %b pos %h vel %h",
                                 $realtime, want.torque, want.drive, want.angle, want.vel);
                        $display("%0t:          actual torque %h drive %b pos %h vel %h",
                                 $realtime, m_tdata[31:0], m_tuser, m_tdata[63:32],
                                 m_tdata[95:64]);
                        errors++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    jqtpd_pkg::REG_KP:      kp = 64'(cfg_data[30:0]);
                    jqtpd_pkg::REG_KD:      kd = 64'(cfg_data[30:0]);
                    jqtpd_pkg::REG_INERTIA: inertia = 64'(cfg_data[30:0]);
                    jqtpd_pkg::REG_LIMIT:   tlimit = 64'(cfg_data[30:0]);
                    jqtpd_pkg::REG_PERIOD:  period = 64'(cfg_data);
                    jqtpd_pkg::REG_RATE:    rate = 64'(cfg_data[19:0]);
                    jqtpd_pkg::REG_SIM:     sim = cfg_data[0];
                    jqtpd_pkg::REG_HOME: begin
                        hv = cfg_data;
                        home = longint'(hv);
                        des_angle = longint'(hv);
                    end
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) want_q.push_back(servo_tick(s_tuser, s_tdata));
        end
        pending = want_q.size();
    end

endmodule

### test/tb_joint_quintic_trajectory_pd_core.sv
`timescale 1ns / 1ps

module tb_joint_quintic_trajectory_pd_core;

    localparam int STALL_LIMIT = 40000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = jqtpd_pkg::OP_IDLE;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = jqtpd_pkg::REG_KP;
    logic [31:0] cfg_data = '0;
    int          pending;
    int          errors;
    int          quiet_cycles = 0;
    logic [31:0] near_pos = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    joint_quintic_trajectory_pd_core DUT (.*);

    jqtpd_checker u_checker (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    initial begin
        int n, long_hold;
        long_hold = 0;
        n = 0;
        @(posedge aclk);
        wait (aresetn);
        forever begin
            n++;
            if (n == 300 && !long_hold) begin
                long_hold = 1;
                @(posedge aclk) m_tready <= 0;
                repeat (4000) @(posedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                @(posedge aclk) m_tready <= 0;
                repeat (pick_gap()) @(posedge aclk);
            end
            @(posedge aclk) m_tready <= 1;
            repeat ($urandom_range(0, 30)) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic send_tick(logic [1:0] op, logic [31:0] meas, logic [31:0] tgt,
                             logic [30:0] dur);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {1'b0, dur, tgt, meas};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic load_all(logic [31:0] kp, logic [31:0] kd, logic [31:0] inr,
                            logic [31:0] lim, logic [31:0] per, logic [31:0] rt,
                            logic sm, logic [31:0] hm);
        write_reg(jqtpd_pkg::REG_KP, kp);
        write_reg(jqtpd_pkg::REG_KD, kd);
        write_reg(jqtpd_pkg::REG_INERTIA, inr);
        write_reg(jqtpd_pkg::REG_LIMIT, lim);
        write_reg(jqtpd_pkg::REG_PERIOD, per);
        write_reg(jqtpd_pkg::REG_RATE, rt);
        write_reg(jqtpd_pkg::REG_SIM, {31'b0, sm});
        write_reg(jqtpd_pkg::REG_HOME, hm);
        near_pos = hm;
    endtask

    task automatic random_tick();
        int r;
        logic [1:0] op;
        logic [31:0] meas, tgt;
        logic [30:0] dur;
        r = $urandom_range(0, 99);
        op = r < 14 ? jqtpd_pkg::OP_START :
             (r < 82 ? jqtpd_pkg::OP_TRACK :
              (r < 92 ? jqtpd_pkg::OP_IDLE : jqtpd_pkg::OP_SPARE));
        meas = $urandom_range(0, 4) == 0 ? $urandom
                                         : near_pos + $urandom_range(0, 8192) - 4096;
        if ($urandom_range(0, 3) == 0) tgt = $urandom;
        else tgt = near_pos + $urandom_range(0, 32'h60000) - 32'h30000;
        r = $urandom_range(0, 99);
        if (r < 12) dur = 0;
        else if (r < 75) dur = 31'($urandom_range(1, 32'h30000));
        else if (r < 90) dur = 31'($urandom_range(1, 32'h4000));
        else dur = 31'($urandom);
        if (op == jqtpd_pkg::OP_START) near_pos = tgt;
        send_tick(op, meas, tgt, dur);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        load_all(32'h20000, 32'h1999, 32'h10000, 32'h7fffffff, 32'd214748364,
                 32'd20, 1'b0, 32'h10000);
        send_tick(jqtpd_pkg::OP_IDLE, 32'h10000, 0, 0);
        send_tick(jqtpd_pkg::OP_TRACK, 32'h10000, 0, 0);
        send_tick(jqtpd_pkg::OP_START, 32'h10000, 32'h30000, 0);
        send_tick(jqtpd_pkg::OP_TRACK, 32'h28000, 0, 0);
        send_tick(jqtpd_pkg::OP_START, 32'h30000, 32'h10000, 31'h10000);
        repeat (6) send_tick(jqtpd_pkg::OP_TRACK, 32'h2c000, 32'hffffffff, 31'h7fffffff);
        send_tick(jqtpd_pkg::OP_SPARE, 32'h7fffffff, 32'h80000000, 31'h7fffffff);
        send_tick(jqtpd_pkg::OP_START, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
        send_tick(jqtpd_pkg::OP_TRACK, 32'h80000000, 0, 0);
        send_tick(jqtpd_pkg::OP_START, 32'h7fffffff, 32'h80000000, 31'd1);
        send_tick(jqtpd_pkg::OP_TRACK, 32'h7fffffff, 0, 0);
        send_tick(jqtpd_pkg::OP_TRACK, 32'h80000000, 0, 0);
        send_tick(jqtpd_pkg::OP_IDLE, 32'hffffffff, 0, 0);
        send_tick(jqtpd_pkg::OP_START, 32'h0, 32'h0, 31'h5555);
        send_tick(jqtpd_pkg::OP_TRACK, 32'haaaaaaaa, 32'h55555555, 31'h2aaaaaaa);
        repeat (130) random_tick();
        drain();

        for (int ph = 1; ph < 6; ph++) begin
            case (ph)
                1: load_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'hffffffff, 32'd1000000, 1'b0, 32'h7fffffff);
                2: load_all(0, 0, 0, 0, 32'd1, 32'd0, 1'b1, 32'h80000000);
                3: load_all($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom_range(1, 1000000), 1'b0, $urandom);
                4: load_all($urandom_range(0, 32'h100000), $urandom_range(0, 32'h40000),
                            $urandom_range(0, 32'h40000), $urandom, $urandom,
                            $urandom_range(1, 5000), 1'b1, $urandom);
                default: load_all($urandom_range(0, 32'h100000),
                                  $urandom_range(0, 32'h40000),
                                  $urandom_range(1, 32'h40000), $urandom_range(0, 32'hfffff),
                                  $urandom_range(32'd4294967, 32'd1073741824),
                                  $urandom_range(1, 2000), 1'b0, $urandom);
            endcase
            repeat (140) random_tick();
            drain();
        end

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
